### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ECWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ECWP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ECWP_ASSERT(lbl, prop, msg)
`define ECWP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### design/ecwp_pkg.sv
// shared constants and types of the eye closure window block
package ecwp_pkg;

  localparam int unsigned CAP_W = 11;
  localparam int unsigned QW    = 14;
  localparam logic [QW-1:0] FULL_SCALE = 14'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } ecwp_state_e;

  typedef struct packed {
    logic          busy;
    logic [QW-1:0] quot;
  } ecwp_div_res_t;

endpackage

### design/ecwp_if.sv
// valid/ready channel interfaces for the input flag and the result pair
interface ecwp_in_if;
  logic valid;
  logic ready;
  logic eye_closed;

  modport source (output valid, output eye_closed, input ready);
  modport sink   (input valid, input eye_closed, output ready);
endinterface

interface ecwp_out_if import ecwp_pkg::*; ;
  logic          valid;
  logic          ready;
  logic [QW-1:0] closure_centi_percent;
  logic [QW-1:0] availability_centi_percent;

  modport source (output valid, output closure_centi_percent,
                  output availability_centi_percent, input ready);
  modport sink   (input valid, input closure_centi_percent,
                  input availability_centi_percent, output ready);
endinterface

### design/ecwp_ram.sv
// generic single-write, single-read ram with registered read data
module ecwp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ecwp_div.sv
// bit-serial restoring divider for scaled ratios, one quotient bit per cycle
module ecwp_div import ecwp_pkg::*; #(
  parameter int unsigned DW = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW+QW-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output ecwp_div_res_t    res_o
);

  localparam int unsigned NW  = DW + QW;
  localparam int unsigned CNW = $clog2(QW + 1);

  logic           busy_q, busy_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]  r_q, r_d;
  logic [QW-1:0]  sh_q, sh_d;
  logic [QW-1:0]  quot_q, quot_d;
  logic [DW-1:0]  den_q, den_d;
  logic           zero_q, zero_d;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  assign trial = {r_q, sh_q[QW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    sh_d   = sh_q;
    quot_d = quot_q;
    den_d  = den_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNW'(QW);
      r_d    = dividend_i[NW-1:QW];
      sh_d   = dividend_i[QW-1:0];
      quot_d = '0;
      den_d  = divisor_i;
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      r_d    = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_d   = {sh_q[QW-2:0], 1'b0};
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    sh_q   <= sh_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

  always_comb begin
    res_o.busy = busy_q;
    if (zero_q) begin
      res_o.quot = '0;
    end else if (quot_q > FULL_SCALE) begin
      res_o.quot = FULL_SCALE;
    end else begin
      res_o.quot = quot_q;
    end
  end

endmodule

### design/eye_closure_window_percentage_top.sv
// top level of the sliding-window eye closure percentage tracker
//
//   channel  dir  payload                                              handshake
//   cfg      in   cfg_wdata_i (window capacity)                        cfg_we_i
//   in_i     in   eye_closed                                           valid/ready
//   out_o    out  closure_centi_percent, availability_centi_percent    valid/ready
//
// an item passes from its transfer through the update, start, divide and output states to a
// registered result; the two 14-step bit-serial dividers run side by side
// the next item is taken once the result sits in the output register
// a capacity write empties the window by clearing its position and counts; the flag ram has no clearing pass
// a stalled output holds its result; the next item waits in its last step until it moves on
module eye_closure_window_percentage_top import ecwp_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  ecwp_in_if.sink            in_i,
  ecwp_out_if.source         out_o
);

`include "assert_macros.svh"

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned XW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned NW = CW + QW;

  ecwp_state_e state_q, state_d;

  logic [CAP_W-1:0] cap_q;
  logic [AW-1:0]    wpos_q, wpos_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    closed_q, closed_d;
  logic             full_q, full_d;
  logic             flag_q, flag_d;
  logic             pushed_q, pushed_d;

  logic             out_valid_q, out_valid_d;
  logic [QW-1:0]    out_clo_q, out_clo_d;
  logic [QW-1:0]    out_ava_q, out_ava_d;

  logic [XW-1:0]    cap_x;
  logic [CW-1:0]    cap_eff;
  logic [CW-1:0]    pos_full;
  logic [CW-1:0]    pos_next;
  logic [AW-1:0]    pos;
  logic             accept;
  logic             ram_we;
  logic             old_flag;
  logic             drop;
  logic             div_start;
  ecwp_div_res_t    res_clo, res_ava;

  assign cap_x   = (XW'(cap_q) > XW'(WINDOW_MAX)) ? XW'(WINDOW_MAX) : XW'(cap_q);
  assign cap_eff = cap_x[CW-1:0];

  assign pos_full = (CW'(wpos_q) >= cap_eff) ? '0 : CW'(wpos_q);
  assign pos      = pos_full[AW-1:0];
  assign pos_next = ((pos_full + CW'(1)) >= cap_eff) ? '0 : (pos_full + CW'(1));

  assign accept = in_i.valid && in_i.ready;
  assign ram_we = accept && (cap_eff != '0);
  assign drop   = full_q && old_flag && (closed_q != '0);

  ecwp_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos),
    .wdata_i (in_i.eye_closed),
    .raddr_i (pos),
    .rdata_o (old_flag)
  );

  ecwp_div #(.DW(CW)) u_div_clo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (NW'(closed_q) * NW'(FULL_SCALE)),
    .divisor_i  (fill_q),
    .res_o      (res_clo)
  );

  ecwp_div #(.DW(CW)) u_div_ava (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (NW'(fill_q) * NW'(FULL_SCALE)),
    .divisor_i  (cap_eff),
    .res_o      (res_ava)
  );

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    fill_d      = fill_q;
    closed_d    = closed_q;
    full_d      = full_q;
    flag_d      = flag_q;
    pushed_d    = pushed_q;
    out_valid_d = out_valid_q;
    out_clo_d   = out_clo_q;
    out_ava_d   = out_ava_q;
    div_start   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          flag_d   = in_i.eye_closed;
          pushed_d = (cap_eff != '0);
          full_d   = (fill_q >= cap_eff);
          if (cap_eff != '0) begin
            fill_d = (fill_q >= cap_eff) ? cap_eff : (fill_q + CW'(1));
            wpos_d = pos_next[AW-1:0];
          end
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (pushed_q) begin
          closed_d = closed_q + CW'(flag_q) - CW'(drop);
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!res_clo.busy && !res_ava.busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_clo_d   = res_clo.quot;
          out_ava_d   = res_ava.quot;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      wpos_d   = '0;
      fill_d   = '0;
      closed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= '0;
      wpos_q      <= '0;
      fill_q      <= '0;
      closed_q    <= '0;
      full_q      <= 1'b0;
      pushed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      fill_q      <= fill_d;
      closed_q    <= closed_d;
      full_q      <= full_d;
      pushed_q    <= pushed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q    <= flag_d;
    out_clo_q <= out_clo_d;
    out_ava_q <= out_ava_d;
  end

  assign in_i.ready                       = (state_q == ST_IDLE);
  assign out_o.valid                      = out_valid_q;
  assign out_o.closure_centi_percent      = out_clo_q;
  assign out_o.availability_centi_percent = out_ava_q;

  `ECWP_ASSERT(a_fill_le_cap, fill_q <= cap_eff, "fill count above capacity")
  `ECWP_ASSERT(a_closed_le_fill, closed_q <= fill_q, "closed count above fill count")
  `ECWP_ASSERT(a_div_lockstep, res_clo.busy == res_ava.busy, "dividers out of step")
  `ECWP_ASSERT(a_accept_upd, accept |=> state_q == ST_UPD, "transfer not followed by update")
  `ECWP_ASSERT_RST(a_out_range, out_valid_q |-> (out_clo_q <= FULL_SCALE) &&
    (out_ava_q <= FULL_SCALE), "result above full scale")

endmodule

### sim/tb_eye_closure_window_percentage_top.sv
// testbench for the sliding-window eye closure percentage tracker, with scoreboard
module tb_eye_closure_window_percentage_top import ecwp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  class perclos_scoreboard #(int unsigned DEPTH = 1024);
    typedef struct {
      logic [QW-1:0] closure;
      logic [QW-1:0] avail;
    } pct_pair_t;

    bit              flag_ring[DEPTH];
    int unsigned     wr_pos;
    int unsigned     fill;
    int unsigned     closed;
    int unsigned     capacity;
    pct_pair_t       pending[$];
    int              errors;

    function new();
      foreach (flag_ring[i]) flag_ring[i] = 1'b0;
      capacity = 0;
      errors   = 0;
      clear_window();
    endfunction

    function void clear_window();
      wr_pos = 0;
      fill   = 0;
      closed = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
      clear_window();
    endfunction

    function int unsigned centi_share(int unsigned num, int unsigned den);
      int unsigned q;
      if (den == 0) return 0;
      q = (num * 10000) / den;
      if (q > 10000) q = 10000;
      return q;
    endfunction

    function void note_flag(bit closed_flag);
      int unsigned eff_cap;
      int unsigned pos;
      pct_pair_t   exp_pair;
      eff_cap = (capacity > DEPTH) ? DEPTH : capacity;
      if (eff_cap != 0) begin
        pos = (wr_pos >= eff_cap) ? 0 : wr_pos;
        if (fill >= eff_cap) begin
          // full window: the oldest flag leaves
          if (flag_ring[pos] && closed > 0) closed--;
          fill = eff_cap;
        end else begin
          fill++;
        end
        flag_ring[pos] = closed_flag;
        if (closed_flag) closed++;
        pos++;
        wr_pos = (pos >= eff_cap) ? 0 : pos;
      end
      exp_pair.closure = QW'(centi_share(closed, fill));
      exp_pair.avail   = QW'(centi_share(fill, eff_cap));
      pending = {pending, exp_pair};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [QW-1:0] closure, logic [QW-1:0] avail);
      pct_pair_t exp_pair;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result closure=%0d avail=%0d", closure, avail));
      end else begin
        exp_pair = pending.pop_front();
        if (closure !== exp_pair.closure)
          report($sformatf("closure got %0d exp %0d", closure, exp_pair.closure));
        if (avail !== exp_pair.avail)
          report($sformatf("availability got %0d exp %0d", avail, exp_pair.avail));
      end
    endtask
  endclass

  localparam int unsigned RING_DEPTH   = 1024;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  ecwp_in_if  flag_if ();
  ecwp_out_if pct_if ();

  perclos_scoreboard #(RING_DEPTH) sb;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned cycle_count;

  eye_closure_window_percentage_top #(
    .WINDOW_MAX(RING_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (flag_if),
    .out_o      (pct_if)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pct_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pct_if.valid && pct_if.ready)
      sb.check_result(pct_if.closure_centi_percent, pct_if.availability_centi_percent);
  end

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
      default: begin src_idle_pct = 15; sink_stall_pct = 15; end
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_capacity(cap);
  endtask

  task automatic send_flags(input bit flags[$]);
    foreach (flags[i]) begin
      while ($urandom_range(99) < src_idle_pct) begin
        flag_if.valid = 1'b0;
        @(negedge clk_i);
      end
      flag_if.valid      = 1'b1;
      flag_if.eye_closed = flags[i];
      do @(posedge clk_i); while (!flag_if.ready);
      sb.note_flag(flags[i]);
      @(negedge clk_i);
    end
    flag_if.valid = 1'b0;
  endtask

  task automatic send_random(input int unsigned count, input int unsigned closed_pct);
    bit flags[$];
    repeat (count) flags = {flags, ($urandom_range(99) < closed_pct)};
    send_flags(flags);
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    int unsigned      closed_pct;

    sb                 = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    flag_if.valid      = 1'b0;
    flag_if.eye_closed = 1'b0;
    pct_if.ready       = 1'b0;
    cycle_count        = 0;
    set_idling(0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero capacity after reset
    send_flags('{1'b1, 1'b0});
    // small window: fill, wrap, drop closed and open flags
    write_capacity(3);
    send_flags('{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0});
    // rewriting the same value empties the window
    write_capacity(3);
    send_flags('{1'b1});
    write_capacity(1);
    send_flags('{1'b1, 1'b0, 1'b1, 1'b1});
    // capacity above the ring size saturates
    write_capacity(2047);
    send_flags('{1'b1, 1'b0, 1'b1});
    write_capacity(RING_DEPTH);
    send_flags('{1'b0, 1'b1});
    write_capacity(0);
    send_flags('{1'b1});

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(9))
        0: cap = '0;
        1: cap = CAP_W'($urandom_range(2047));
        2: cap = CAP_W'(RING_DEPTH + $urandom_range(1023));
        default: cap = CAP_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(3))
        0: closed_pct = 0;
        1: closed_pct = 100;
        2: closed_pct = 50;
        default: closed_pct = $urandom_range(100);
      endcase
      write_capacity(cap);
      set_idling(ph);
      send_random($urandom_range(20, 36), closed_pct);
      set_idling(0);
    end

    // long run in a saturated full-size window
    write_capacity(2047);
    set_idling(3);
    send_random(100, 30);
    set_idling(0);

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
